// ===== rtl/core/fns_pkg.sv =====
// ----------------------------------------------------------------------------
// fns_pkg
// Shared widths, constants and sequencer states for the Newton square root.
// ----------------------------------------------------------------------------
package fns_pkg;

   // field widths
   localparam int unsigned ValW    = 31;              // Q15.16 radicand / root
   localparam int unsigned LimW    = 4;               // iteration limit register
   localparam int unsigned TolW    = 16;              // tolerance register
   localparam int unsigned CsrW    = 16;              // widest register
   localparam int unsigned ReqW    = 32;              // request tdata, byte padded
   localparam int unsigned RspW    = 32;              // response tdata
   localparam int unsigned FracW   = 16;              // fraction bits

   // datapath widths
   localparam int unsigned SqW     = 2 * ValW;        // estimate squared
   localparam int unsigned ResW    = SqW - FracW + 2; // signed residual
   localparam int unsigned DvdW    = 63;              // |residual| << 16
   localparam int unsigned DivW    = ValW + 2;        // twice the estimate, 33 bits
   localparam int unsigned CntW    = 6;               // division step counter
   localparam int unsigned SumW    = DvdW + 2;        // estimate update

   // constants
   localparam logic [ValW-1:0] OneQ16    = ValW'(1 << FracW);
   localparam logic [ValW-1:0] RootMax   = '1;
   localparam logic [LimW-1:0] LimReset  = LimW'(8);
   localparam logic [TolW-1:0] TolReset  = TolW'(1 << 2);
   localparam logic [CntW-1:0] DivSteps  = CntW'(DvdW - 1);

   // register indexes
   localparam logic CsrLimit = 1'b0;
   localparam logic CsrTol   = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_RESID  = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/fixed_point_newton_sqrt.sv =====
// ----------------------------------------------------------------------------
// fixed_point_newton_sqrt
// Q15.16 square root by Newton iteration with early stop on tolerance.
// ----------------------------------------------------------------------------
// One request at a time: the estimate starts at 1.0 and each Newton pass is a
// squaring multiply, a residual step, a 63-step restoring divider that retires
// one quotient bit a cycle, and an update step. A request runs as many passes
// as the iteration limit (8 by default), fewer when the correction falls below
// tolerance early. The divider is the long pole. req_tready is high only while
// no request is being worked on; a finished response sits in an output register
// so the next request can be taken while it waits. With an iteration limit of
// zero the response is 1.0, not converged. Registers: index 0 iteration limit,
// index 1 tolerance.
module fixed_point_newton_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [fns_pkg::ReqW-1:0]   req_tdata,   // [30:0] radicand, [31] zero
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [fns_pkg::RspW-1:0]   rsp_tdata,   // [30:0] root, [31] converged
   // register writes
   input  logic                       csr_wen,
   input  logic                       csr_index,
   input  logic [fns_pkg::CsrW-1:0]   csr_wdata
);
   import fns_pkg::*;

   state_type            state_ff, state_in;
   logic [LimW-1:0]      limit_ff, limit_in;
   logic [TolW-1:0]      tol_ff, tol_in;
   logic [ValW-1:0]      x_ff, x_in;
   logic [ValW-1:0]      est_ff, est_in;
   logic [SqW-1:0]       sq_ff, sq_in;
   logic [DvdW-1:0]      dvd_ff, dvd_in;
   logic [DivW-1:0]      rem_ff, rem_in;
   logic [DivW-1:0]      div_ff, div_in;
   logic                 neg_ff, neg_in;
   logic                 divz_ff, divz_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [LimW-1:0]      pass_ff, pass_in;
   logic                 conv_ff, conv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]      rsp_data_ff, rsp_data_in;

   logic signed [ResW-1:0] resid;
   logic [ResW-1:0]        resid_mag;
   logic [DivW:0]          shifted;
   logic [DivW:0]          trial;
   logic                   fits;
   logic [DvdW-1:0]        quot;
   logic [SumW-1:0]        sum;
   logic [ValW-1:0]        est_sat;
   logic                   small_corr;
   logic [LimW-1:0]        pass_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // residual: floor(est^2 / 2^16) - radicand, and its magnitude
   assign resid     = $signed({2'b00, sq_ff[SqW-1:FracW]}) -
                      $signed({{(ResW-ValW){1'b0}}, x_ff});
   assign resid_mag = resid[ResW-1] ? ResW'(-resid) : ResW'(resid);

   // one restoring division step
   assign shifted = {rem_ff, dvd_ff[DvdW-1]};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign trial   = shifted - {1'b0, div_ff};

   // estimate update with saturation to [0, 2^31-1]
   assign quot       = divz_ff ? '0 : dvd_ff;
   assign sum        = neg_ff ? ({{(SumW-ValW){1'b0}}, est_ff} + {2'b00, quot})
                              : ({{(SumW-ValW){1'b0}}, est_ff} - {2'b00, quot});
   assign est_sat    = sum[SumW-1] ? '0 :
                       (|sum[SumW-2:ValW]) ? RootMax : sum[ValW-1:0];
   assign small_corr = (quot[DvdW-1:TolW] == '0) && (quot[TolW-1:0] < tol_ff);
   assign pass_next  = pass_ff + LimW'(1);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      tol_in       = tol_ff;
      x_in         = x_ff;
      est_in       = est_ff;
      sq_in        = sq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      divz_in      = divz_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      conv_in      = conv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_wen) begin
         unique case (csr_index)
            CsrLimit: limit_in = csr_wdata[LimW-1:0];
            CsrTol:   tol_in   = csr_wdata[TolW-1:0];
            default:  tol_in   = tol_ff;
         endcase
      end

      // response leaves on handshake
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in    = req_tdata[ValW-1:0];
               est_in  = OneQ16;
               pass_in = '0;
               conv_in = 1'b0;
               state_in = (limit_ff == '0) ? ST_FINISH : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = {{(SqW-ValW){1'b0}}, est_ff} * {{(SqW-ValW){1'b0}}, est_ff};
            state_in = ST_RESID;
         end
         ST_RESID: begin
            neg_in   = resid[ResW-1];
            dvd_in   = {resid_mag[DvdW-FracW-1:0], {FracW{1'b0}}};
            rem_in   = '0;
            div_in   = {1'b0, est_ff, 1'b0};
            divz_in  = (est_ff == '0);
            cnt_in   = DivSteps;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = fits ? trial[DivW-1:0] : shifted[DivW-1:0];
            dvd_in = {dvd_ff[DvdW-2:0], fits};
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            est_in  = est_sat;
            pass_in = pass_next;
            priority if (small_corr) begin
               conv_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (pass_next == limit_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {conv_ff, est_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LimReset;
         tol_ff       <= TolReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      est_ff      <= est_in;
      sq_ff       <= sq_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      divz_ff     <= divz_in;
      cnt_ff      <= cnt_in;
      pass_ff     <= pass_in;
      conv_ff     <= conv_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
